// ===== design/gik_pkg.sv =====
// shared types, codes and constants for the isotropic gabor kernel block
// used by gik_ctrl, gik_datapath and gabor_iso_kernel_core; no dependencies
package gik_pkg;

    // datapath operation codes, one per step of the shared multiplier
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACC,
        OP_D2_HI,
        OP_D2_LO,
        OP_DP_HI,
        OP_DP_LO,
        OP_T,
        OP_Z,
        OP_EA,
        OP_EB,
        OP_SX,
        OP_SX2,
        OP_SH,
        OP_SF,
        OP_KM,
        OP_WM,
        OP_G1,
        OP_P1,
        OP_P2,
        OP_G2
    } gik_op_t;

    // controller to datapath
    typedef struct packed {
        gik_op_t    op;
        logic       sel_cos;
        logic [2:0] cnt;
        logic       load_in;
        logic       out_load;
    } gik_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } gik_status_t;

    // register indexes
    localparam logic [7:0] CFG_INV_LENGTH_SQ = 8'd0;
    localparam logic [7:0] CFG_INV_PERIOD    = 8'd1;

    localparam logic [31:0] INV_RESET      = 32'd65536;
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [31:0] HALF_LOG2E_Q32 = 32'd3098164012;
    localparam logic [29:0] LN2_Q30        = 30'd744261118;
    localparam logic [30:0] TWO_PI_Q28     = 31'd1686629713;
    localparam logic [31:0] SIN_C9         = 32'd172272;

    // ceil(2^33 / k) for k = idx + 1, exact quotient for 30-bit dividends
    function automatic logic [33:0] recip_k(input logic [2:0] idx);
        logic [33:0] r;
        begin
            case (idx)
                3'd0:    r = 34'd8589934592;
                3'd1:    r = 34'd4294967296;
                3'd2:    r = 34'd2863311531;
                3'd3:    r = 34'd2147483648;
                3'd4:    r = 34'd1717986919;
                3'd5:    r = 34'd1431655766;
                3'd6:    r = 34'd1227133514;
                default: r = 34'd1073741824;
            endcase
            return r;
        end
    endfunction

    // quarter-wave sine coefficients, index 3 is the first horner step
    function automatic logic [31:0] sin_coef(input logic [1:0] idx);
        logic [31:0] c;
        begin
            case (idx)
                2'd0:    c = 32'd1686629713;
                2'd1:    c = 32'd693598669;
                2'd2:    c = 32'd85569306;
                default: c = 32'd5026995;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== design/gik_ctrl.sv =====
// sequencer for the gabor kernel: input handshake, accumulation and
// the multiply schedule of the final evaluation; uses gik_pkg
module gik_ctrl #(
    parameter int DIMENSIONS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output gik_pkg::gik_cmd_t    cmd,
    input  gik_pkg::gik_status_t status
);
    import gik_pkg::*;

    localparam int CW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam logic [CW-1:0] LAST = CW'(DIMENSIONS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_CALC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    gik_op_t       op_reg, op_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          sel_reg, sel_next;
    logic [CW-1:0] coord_reg, coord_next;

    // next state and command
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        coord_next   = coord_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.sel_cos  = sel_reg;
        cmd.cnt      = cnt_reg;
        cmd.load_in  = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                if (coord_reg == LAST)
                begin
                    coord_next = '0;
                    state_next = ST_CALC;
                    op_next    = OP_D2_HI;
                end
                else
                begin
                    coord_next = coord_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CALC:
            begin
                cmd.op = op_reg;
                case (op_reg)
                    OP_D2_HI: op_next = OP_D2_LO;
                    OP_D2_LO: op_next = OP_DP_HI;
                    OP_DP_HI: op_next = OP_DP_LO;
                    OP_DP_LO: op_next = OP_T;
                    OP_T:     op_next = OP_Z;
                    OP_Z:
                    begin
                        op_next  = OP_EA;
                        cnt_next = 3'd7;
                    end
                    OP_EA:    op_next = OP_EB;
                    OP_EB:
                    begin
                        if (cnt_reg == 3'd0)
                        begin
                            op_next  = OP_SX;
                            sel_next = 1'b1;
                        end
                        else
                        begin
                            op_next  = OP_EA;
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    OP_SX:
                    begin
                        op_next  = OP_SX2;
                        cnt_next = 3'd3;
                    end
                    OP_SX2:   op_next = OP_SH;
                    OP_SH:
                    begin
                        if (cnt_reg == 3'd0)
                            op_next = OP_SF;
                        else
                            cnt_next = cnt_reg - 1'b1;
                    end
                    OP_SF:
                    begin
                        if (sel_reg)
                        begin
                            sel_next = 1'b0;
                            op_next  = OP_SX;
                        end
                        else
                            op_next = OP_KM;
                    end
                    OP_KM:    op_next = OP_WM;
                    OP_WM:    op_next = OP_G1;
                    OP_G1:    op_next = OP_P1;
                    OP_P1:    op_next = OP_P2;
                    OP_P2:    op_next = OP_G2;
                    OP_G2:
                    begin
                        op_next    = OP_NONE;
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        op_next    = OP_NONE;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            coord_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            coord_reg <= coord_next;
        end
    end

endmodule

// ===== design/gik_datapath.sv =====
// datapath of the gabor kernel: accumulators, one shared 34x34 multiplier,
// exp and sine stepping registers, config registers and output register; uses gik_pkg
module gik_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gik_pkg::gik_cmd_t    cmd,
    output gik_pkg::gik_status_t status,
    input  logic [63:0]          in_data,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [95:0]          out_data
);
    import gik_pkg::*;

    // saturate a magnitude and sign to a 32-bit two's complement value
    function automatic logic [31:0] sat32(input logic [35:0] mag, input logic neg);
        logic [35:0] m;
        begin
            if (neg)
            begin
                m = (mag > 36'h0_8000_0000) ? 36'h0_8000_0000 : mag;
                m = ~m + 36'd1;
            end
            else
                m = (mag > 36'h0_7FFF_FFFF) ? 36'h0_7FFF_FFFF : mag;
            return m[31:0];
        end
    endfunction

    // control and state registers (reset)
    logic [31:0] ils_reg, ils_next;
    logic [31:0] ip_reg, ip_next;
    logic [63:0] ss_reg, ss_next;
    logic [39:0] ds_reg, ds_next;
    logic        mvalid_reg, mvalid_next;

    // payload registers
    logic [32:0] diff_reg, diff_next;
    logic [63:0] hi_reg, hi_next;
    logic [39:0] amag_reg, amag_next;
    logic        dneg_reg, dneg_next;
    logic [31:0] d2_reg, d2_next;
    logic [56:0] dpm_reg, dpm_next;
    logic [15:0] phase_reg, phase_next;
    logic [31:0] t_reg, t_next;
    logic [29:0] z_reg, z_next;
    logic [30:0] e_reg, e_next;
    logic [29:0] tmp_reg, tmp_next;
    logic [30:0] x_reg, x_next;
    logic [30:0] x2_reg, x2_next;
    logic [31:0] poly_reg, poly_next;
    logic        qneg_reg, qneg_next;
    logic [30:0] kexp_reg, kexp_next;
    logic [30:0] cmag_reg, cmag_next;
    logic [30:0] smag_reg, smag_next;
    logic        cneg_reg, cneg_next;
    logic        sneg_reg, sneg_next;
    logic [30:0] km_reg, km_next;
    logic [30:0] wm_reg, wm_next;
    logic [32:0] prod_reg, prod_next;
    logic [31:0] kv_reg, kv_next;
    logic [31:0] gl_reg, gl_next;
    logic [31:0] gp_reg, gp_next;
    logic [95:0] mdata_reg, mdata_next;

    logic [33:0] mul_a, mul_b;
    logic [67:0] mul_p;
    logic [32:0] adiff;

    logic [64:0] ss_sum;
    logic [40:0] ds_sum;
    logic [63:0] d2_sum;
    logic [56:0] dpm_v;
    logic [15:0] ph16;
    logic [14:0] x15;
    logic [31:0] sf_v;
    logic [30:0] sf_c;
    logic [30:0] km_v;
    logic [59:0] pr_sum;
    logic [35:0] g_v;

    assign adiff = diff_reg[32] ? (~diff_reg + 33'd1) : diff_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_ACC:
            begin
                mul_a = {1'b0, adiff};
                mul_b = {1'b0, adiff};
            end
            OP_D2_HI:
            begin
                mul_a = {2'b0, ss_reg[63:32]};
                mul_b = {2'b0, ils_reg};
            end
            OP_D2_LO:
            begin
                mul_a = {2'b0, ss_reg[31:0]};
                mul_b = {2'b0, ils_reg};
            end
            OP_DP_HI:
            begin
                mul_a = {26'b0, amag_reg[39:32]};
                mul_b = {2'b0, ip_reg};
            end
            OP_DP_LO:
            begin
                mul_a = {2'b0, amag_reg[31:0]};
                mul_b = {2'b0, ip_reg};
            end
            OP_T:
            begin
                mul_a = {2'b0, d2_reg};
                mul_b = {2'b0, HALF_LOG2E_Q32};
            end
            OP_Z:
            begin
                mul_a = {18'b0, t_reg[15:0]};
                mul_b = {4'b0, LN2_Q30};
            end
            OP_EA:
            begin
                mul_a = {4'b0, z_reg};
                mul_b = {3'b0, e_reg};
            end
            OP_EB:
            begin
                mul_a = {4'b0, tmp_reg};
                mul_b = recip_k(cmd.cnt);
            end
            OP_SX2:
            begin
                mul_a = {3'b0, x_reg};
                mul_b = {3'b0, x_reg};
            end
            OP_SH:
            begin
                mul_a = {3'b0, x2_reg};
                mul_b = {2'b0, poly_reg};
            end
            OP_SF:
            begin
                mul_a = {3'b0, x_reg};
                mul_b = {2'b0, poly_reg};
            end
            OP_KM:
            begin
                mul_a = {3'b0, kexp_reg};
                mul_b = {3'b0, cmag_reg};
            end
            OP_WM:
            begin
                mul_a = {3'b0, kexp_reg};
                mul_b = {3'b0, smag_reg};
            end
            OP_G1:
            begin
                mul_a = {2'b0, d2_reg};
                mul_b = {3'b0, km_reg};
            end
            OP_P1:
            begin
                mul_a = {7'b0, dpm_reg[56:30]};
                mul_b = {3'b0, wm_reg};
            end
            OP_P2:
            begin
                mul_a = {4'b0, dpm_reg[29:0]};
                mul_b = {3'b0, wm_reg};
            end
            OP_G2:
            begin
                mul_a = {1'b0, prod_reg};
                mul_b = {3'b0, TWO_PI_Q28};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next values per operation
    always_comb
    begin
        ils_next    = ils_reg;
        ip_next     = ip_reg;
        ss_next     = ss_reg;
        ds_next     = ds_reg;
        mvalid_next = mvalid_reg;
        diff_next   = diff_reg;
        hi_next     = hi_reg;
        amag_next   = amag_reg;
        dneg_next   = dneg_reg;
        d2_next     = d2_reg;
        dpm_next    = dpm_reg;
        phase_next  = phase_reg;
        t_next      = t_reg;
        z_next      = z_reg;
        e_next      = e_reg;
        tmp_next    = tmp_reg;
        x_next      = x_reg;
        x2_next     = x2_reg;
        poly_next   = poly_reg;
        qneg_next   = qneg_reg;
        kexp_next   = kexp_reg;
        cmag_next   = cmag_reg;
        smag_next   = smag_reg;
        cneg_next   = cneg_reg;
        sneg_next   = sneg_reg;
        km_next     = km_reg;
        wm_next     = wm_reg;
        prod_next   = prod_reg;
        kv_next     = kv_reg;
        gl_next     = gl_reg;
        gp_next     = gp_reg;
        mdata_next  = mdata_reg;

        ss_sum = {1'b0, ss_reg} + {1'b0, mul_p[63:0]};
        ds_sum = {ds_reg[39], ds_reg} + {{8{diff_reg[32]}}, diff_reg};
        d2_sum = hi_reg + {32'b0, mul_p[63:32]};
        dpm_v  = {hi_reg[40:0], 16'b0} + {9'b0, mul_p[63:16]};
        ph16   = cmd.sel_cos ? (phase_reg + 16'h4000) : phase_reg;
        x15    = ph16[14] ? (15'h4000 - {1'b0, ph16[13:0]}) : {1'b0, ph16[13:0]};
        sf_v   = mul_p[61:30];
        sf_c   = (sf_v > {1'b0, Q30_ONE}) ? Q30_ONE : sf_v[30:0];
        km_v   = mul_p[60:30];
        pr_sum = hi_reg[59:0] + {28'b0, mul_p[61:30]};
        g_v    = mul_p[63:28];

        // config writes
        if (cfg_valid)
        begin
            if (cfg_index == CFG_INV_LENGTH_SQ)
                ils_next = cfg_data;
            else if (cfg_index == CFG_INV_PERIOD)
                ip_next = cfg_data;
        end

        // input difference
        if (cmd.load_in)
            diff_next = {in_data[31], in_data[31:0]} - {in_data[63], in_data[63:32]};

        case (cmd.op)
            OP_ACC:
            begin
                ss_next = ss_sum[64] ? '1 : ss_sum[63:0];
                if (ds_sum[40] != ds_sum[39])
                    ds_next = ds_sum[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
                else
                    ds_next = ds_sum[39:0];
            end
            OP_D2_HI:
            begin
                hi_next   = mul_p[63:0];
                amag_next = ds_reg[39] ? (~ds_reg + 40'd1) : ds_reg;
                dneg_next = ds_reg[39];
            end
            OP_D2_LO:
            begin
                d2_next = (|d2_sum[63:32]) ? 32'hFFFF_FFFF : d2_sum[31:0];
            end
            OP_DP_HI:
            begin
                hi_next = {24'b0, mul_p[39:0]};
            end
            OP_DP_LO:
            begin
                dpm_next   = dpm_v;
                phase_next = dneg_reg ? (16'h0 - dpm_v[15:0]) : dpm_v[15:0];
            end
            OP_T:
            begin
                t_next = mul_p[63:32];
            end
            OP_Z:
            begin
                z_next = mul_p[45:16];
                e_next = Q30_ONE;
            end
            OP_EA:
            begin
                tmp_next = mul_p[59:30];
            end
            OP_EB:
            begin
                e_next = Q30_ONE - {1'b0, mul_p[62:33]};
            end
            OP_SX:
            begin
                x_next    = {x15, 16'b0};
                qneg_next = ph16[15];
                if (t_reg[31:16] >= 16'd31)
                    kexp_next = '0;
                else
                    kexp_next = e_reg >> t_reg[20:16];
            end
            OP_SX2:
            begin
                x2_next   = mul_p[60:30];
                poly_next = SIN_C9;
            end
            OP_SH:
            begin
                poly_next = sin_coef(cmd.cnt[1:0]) - mul_p[61:30];
            end
            OP_SF:
            begin
                if (cmd.sel_cos)
                begin
                    cmag_next = sf_c;
                    cneg_next = qneg_reg && (sf_c != '0);
                end
                else
                begin
                    smag_next = sf_c;
                    sneg_next = qneg_reg && (sf_c != '0);
                end
            end
            OP_KM:
            begin
                km_next = km_v;
                kv_next = cneg_reg ? (32'h0 - {1'b0, km_v}) : {1'b0, km_v};
            end
            OP_WM:
            begin
                wm_next = mul_p[60:30];
            end
            OP_G1:
            begin
                gl_next = sat32(mul_p[65:30], cneg_reg && (km_reg != '0));
            end
            OP_P1:
            begin
                hi_next = mul_p[63:0];
            end
            OP_P2:
            begin
                prod_next = (pr_sum > 60'h1_0000_0000) ? 33'h1_0000_0000 : pr_sum[32:0];
            end
            OP_G2:
            begin
                gp_next = sat32(g_v, (dneg_reg != sneg_reg) && (g_v != '0));
            end
            default:
            begin
                hi_next = hi_reg;
            end
        endcase

        // output register and accumulator clear
        if (cmd.out_load)
        begin
            mdata_next  = {gp_reg, gl_reg, kv_reg};
            mvalid_next = 1'b1;
            ss_next     = '0;
            ds_next     = '0;
        end
        else if (out_ready)
            mvalid_next = 1'b0;
    end

    // registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ils_reg    <= INV_RESET;
            ip_reg     <= INV_RESET;
            ss_reg     <= '0;
            ds_reg     <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            ils_reg    <= ils_next;
            ip_reg     <= ip_next;
            ss_reg     <= ss_next;
            ds_reg     <= ds_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        hi_reg    <= hi_next;
        amag_reg  <= amag_next;
        dneg_reg  <= dneg_next;
        d2_reg    <= d2_next;
        dpm_reg   <= dpm_next;
        phase_reg <= phase_next;
        t_reg     <= t_next;
        z_reg     <= z_next;
        e_reg     <= e_next;
        tmp_reg   <= tmp_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        poly_reg  <= poly_next;
        qneg_reg  <= qneg_next;
        kexp_reg  <= kexp_next;
        cmag_reg  <= cmag_next;
        smag_reg  <= smag_next;
        cneg_reg  <= cneg_next;
        sneg_reg  <= sneg_next;
        km_reg    <= km_next;
        wm_reg    <= wm_next;
        prod_reg  <= prod_next;
        kv_reg    <= kv_next;
        gl_reg    <= gl_next;
        gp_reg    <= gp_next;
        mdata_reg <= mdata_next;
    end

    assign status.out_free = !mvalid_reg || out_ready;
    assign out_valid       = mvalid_reg;
    assign out_data        = mdata_reg;

endmodule

// ===== design/gabor_iso_kernel_core.sv =====
// usage:
// isotropic gabor covariance for one pair of points. the slave stream takes
// one coordinate request per item (left and right coordinate, Q16.16); after
// DIMENSIONS requests the master stream presents one result: kernel value
// (Q2.30), gradient for log length and gradient for log period (Q16.16,
// saturating). the config channel writes register 0 (one over squared
// length) and register 1 (one over period), unsigned Q16.16, both 1.0 after
// reset; the config channel is always ready and must only be used while idle.
// each coordinate is accepted, then accumulated. the last one of a pair adds
// the evaluation, run by the single shared 34x34 multiplier that steps
// through the exp and sine series. the result sits in an output register;
// if the receiver stalls, new coordinates are still taken and the next
// result waits until the held one is taken. reset clears the accumulators,
// the sequencer and the output valid.
// gabor_iso_kernel_core: top level, instantiates gik_ctrl and gik_datapath
module gabor_iso_kernel_core #(
    parameter int DIMENSIONS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // left_coord [31:0], right_coord [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // kernel_value [31:0], grad_log_length [63:32],
                                   // grad_log_period [95:64]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gik_pkg::*;

    gik_cmd_t    cmd;
    gik_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    gik_ctrl #(
        .DIMENSIONS(DIMENSIONS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .cmd     (cmd),
        .status  (status)
    );

    // arithmetic
    gik_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule
